// ===== rtl/mcc_pkg.sv =====
// ----------------------------------------------------------------------------
// mcc_pkg: shared types and constants of the misfire crank criteria unit
// Item structs, controller commands and status, divider operand selection.
// ----------------------------------------------------------------------------
package mcc_pkg;

  // divider word width
  localparam int unsigned DIV_W = 32;

  // fixed scaling constants
  localparam logic [31:0] SCALE_DIVISOR = 32'd15625;
  localparam logic [17:0] DELTA_CLAMP   = 18'd262143;
  localparam logic [31:0] LW_CAP        = 32'd199999;
  localparam logic [31:0] BIG_DIFF      = 32'd131071;
  localparam logic [31:0] DBL_LIMIT     = 32'h7FFF_FFFF;
  localparam logic [31:0] POS_FULL      = 32'd32767;
  localparam logic [31:0] NEG_FULL      = 32'd32768;

  // 16384/15625 as a reciprocal with 30 fraction bits, exact for 18-bit deltas
  localparam logic [30:0] SCALE_RECIP   = 31'd1125899907;

  // criterion history slot indexes
  localparam logic [1:0] H_PREV2 = 2'd0;
  localparam logic [1:0] H_PREV  = 2'd1;
  localparam logic [1:0] H_CUR   = 2'd2;
  localparam logic [1:0] H_NEXT  = 2'd3;

  // divider operand selection
  typedef enum logic [1:0] {
    DIV_PRESS_SCALE,
    DIV_PRESS_NORM,
    DIV_COMB
  } div_sel_e;

  typedef struct packed {
    logic [31:0] long_win_delay;
    logic [15:0] half_rev_sum;
    logic [31:0] tdc_win_delay;
    logic [31:0] exp_win_delay;
    logic [31:0] bdc_win_delay;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pfilt_out;
    logic signed [15:0] pfilt_next;
    logic signed [15:0] pfilt_cur;
    logic signed [15:0] pfilt_prev;
    logic signed [15:0] pfilt_prev2;
    logic signed [15:0] comb_out;
    logic signed [15:0] comb_next;
    logic signed [15:0] comb_cur;
    logic signed [15:0] comb_prev;
    logic signed [15:0] comb_prev2;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_e div_sel;
    logic     div_capture;
    logic     commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
  } sts_t;

endpackage

// ===== rtl/mcc_div.sv =====
// ----------------------------------------------------------------------------
// mcc_div: restoring unsigned divider
// One quotient bit per cycle; done pulses for one cycle after the last bit.
// ----------------------------------------------------------------------------
module mcc_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [mcc_pkg::DIV_W-1:0] dividend_i,
  input  logic [mcc_pkg::DIV_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [mcc_pkg::DIV_W-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(mcc_pkg::DIV_W);
  localparam logic [CntW-1:0] LastCnt = CntW'(mcc_pkg::DIV_W - 1);

  logic [mcc_pkg::DIV_W-1:0] rem_q, quo_q, dvs_q;
  logic [CntW-1:0]           cnt_q;
  logic                      busy_q, done_q;
  logic [mcc_pkg::DIV_W:0]   rem_shift;
  logic                      ge;
  logic [mcc_pkg::DIV_W-1:0] rem_d;

  // trial subtraction
  always_comb begin
    rem_shift = {rem_q, quo_q[mcc_pkg::DIV_W-1]};
    ge        = rem_shift >= {1'b0, dvs_q};
    rem_d     = ge ? mcc_pkg::DIV_W'(rem_shift - {1'b0, dvs_q})
                   : rem_shift[mcc_pkg::DIV_W-1:0];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LastCnt) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // operands and partial results
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[mcc_pkg::DIV_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/mcc_dp.sv =====
// ----------------------------------------------------------------------------
// mcc_dp: datapath of the misfire crank criteria unit
// Operand preparation, shared divider, saturation, histories, result register.
// ----------------------------------------------------------------------------
module mcc_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mcc_pkg::in_item_t  in_data_i,
  input  mcc_pkg::cmd_t      cmd_i,
  output mcc_pkg::sts_t      sts_o,
  output mcc_pkg::out_item_t out_data_o
);

  // saturate a magnitude to the criterion range, negating when falling
  function automatic logic [15:0] sat_crit(input logic neg, input logic [31:0] mag);
    logic [16:0] lim;
    logic [16:0] nv;
    begin
      if (neg) begin
        lim = (mag > mcc_pkg::NEG_FULL) ? 17'd32768 : mag[16:0];
        nv  = 17'd0 - lim;
        return nv[15:0];
      end else begin
        lim = (mag > mcc_pkg::POS_FULL) ? 17'd32767 : mag[16:0];
        return lim[15:0];
      end
    end
  endfunction

  // division by four, truncated toward zero
  function automatic logic signed [18:0] div4(input logic signed [18:0] v);
    logic signed [18:0] t;
    begin
      t = v + (v[18] ? 19'sd3 : 19'sd0);
      return t >>> 2;
    end
  endfunction

  logic [17:0]        last_lw_q;
  logic               pup_q;
  logic [17:0]        pd_q;
  logic [15:0]        hrs_q;
  logic [17:0]        lw_cap_q;
  logic [31:0]        sum_q, dbl_q, ex_q;
  logic [18:0]        t1_q;
  logic signed [15:0] pn_q, cn_q;
  logic signed [15:0] p_hist_q [4];
  logic signed [15:0] c_hist_q [4];
  mcc_pkg::out_item_t out_q;

  logic        up;
  logic [31:0] lw_diff;
  logic [32:0] sum_raw;
  logic        cneg, cbig;
  logic [31:0] cd;
  logic [31:0] dividend, divisor;
  logic [31:0] quo, qs;
  logic        div_done;
  logic [48:0] t1_prod;

  // pressure and combustion operands from the incoming item
  always_comb begin
    up      = in_data_i.long_win_delay > {14'd0, last_lw_q};
    lw_diff = up ? in_data_i.long_win_delay - {14'd0, last_lw_q}
                 : {14'd0, last_lw_q} - in_data_i.long_win_delay;
    sum_raw = {1'b0, in_data_i.tdc_win_delay} + {1'b0, in_data_i.bdc_win_delay};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pup_q    <= up;
      pd_q     <= (lw_diff > {14'd0, mcc_pkg::DELTA_CLAMP}) ? mcc_pkg::DELTA_CLAMP
                                                            : lw_diff[17:0];
      hrs_q    <= in_data_i.half_rev_sum;
      lw_cap_q <= (in_data_i.long_win_delay > mcc_pkg::LW_CAP) ? mcc_pkg::LW_CAP[17:0]
                                                               : in_data_i.long_win_delay[17:0];
      sum_q    <= sum_raw[32] ? '1 : sum_raw[31:0];
      dbl_q    <= (in_data_i.exp_win_delay >= mcc_pkg::DBL_LIMIT) ? '1
                  : {in_data_i.exp_win_delay[30:0], 1'b0};
      ex_q     <= in_data_i.exp_win_delay;
    end
  end

  // long window rescale: delta * 16384 / 15625 by reciprocal multiplication
  assign t1_prod = 49'(pd_q) * 49'(mcc_pkg::SCALE_RECIP);

  // combustion difference magnitude
  always_comb begin
    cneg = sum_q > dbl_q;
    cd   = cneg ? sum_q - dbl_q : dbl_q - sum_q;
    cbig = cd > mcc_pkg::BIG_DIFF;
  end

  // divider operand selection
  always_comb begin
    case (cmd_i.div_sel)
      mcc_pkg::DIV_PRESS_SCALE: begin
        dividend = '0;
        divisor  = '0;
      end
      mcc_pkg::DIV_PRESS_NORM: begin
        dividend = {t1_q, 13'd0};
        divisor  = 32'({hrs_q, 2'b00}) + 32'(hrs_q);
      end
      mcc_pkg::DIV_COMB: begin
        dividend = cbig ? cd : {cd[16:0], 15'd0};
        divisor  = ex_q;
      end
      default: begin
        dividend = '0;
        divisor  = '0;
      end
    endcase
  end

  mcc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  assign sts_o.div_done = div_done;

  // large combustion difference: quotient times 32768 before saturation
  assign qs = cbig ? ((quo != '0) ? mcc_pkg::NEG_FULL : '0) : quo;

  // capture of rescale and division results
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_capture) begin
      case (cmd_i.div_sel)
        mcc_pkg::DIV_PRESS_SCALE: t1_q <= t1_prod[48:30];
        mcc_pkg::DIV_PRESS_NORM: begin
          if (hrs_q == '0) pn_q <= pup_q ? 16'sh7FFF : 16'sh8000;
          else             pn_q <= sat_crit(!pup_q, quo);
        end
        mcc_pkg::DIV_COMB: begin
          if (ex_q == '0) cn_q <= 16'sh7FFF;
          else            cn_q <= sat_crit(cneg, qs);
        end
        default: ;
      endcase
    end
  end

  localparam logic [1:0] H_NEXT_IDX = mcc_pkg::H_NEXT;
  localparam logic [1:0] H_CUR_IDX  = mcc_pkg::H_CUR;

  // second differences of the shifted histories
  logic signed [18:0] px, cx, pq, cq;
  always_comb begin
    px = (19'(p_hist_q[H_NEXT_IDX]) <<< 1) - 19'(pn_q) - 19'(p_hist_q[H_CUR_IDX]);
    cx = (19'(c_hist_q[H_NEXT_IDX]) <<< 1) - 19'(cn_q) - 19'(c_hist_q[H_CUR_IDX]);
    pq = div4(px);
    cq = div4(cx + 19'sd2);
  end

  // history shift and last long window on commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        p_hist_q[i] <= '0;
        c_hist_q[i] <= '0;
      end
      last_lw_q <= '0;
    end else if (cmd_i.commit) begin
      p_hist_q[mcc_pkg::H_PREV2] <= p_hist_q[mcc_pkg::H_PREV];
      p_hist_q[mcc_pkg::H_PREV]  <= p_hist_q[mcc_pkg::H_CUR];
      p_hist_q[mcc_pkg::H_CUR]   <= p_hist_q[mcc_pkg::H_NEXT];
      p_hist_q[mcc_pkg::H_NEXT]  <= pn_q;
      c_hist_q[mcc_pkg::H_PREV2] <= c_hist_q[mcc_pkg::H_PREV];
      c_hist_q[mcc_pkg::H_PREV]  <= c_hist_q[mcc_pkg::H_CUR];
      c_hist_q[mcc_pkg::H_CUR]   <= c_hist_q[mcc_pkg::H_NEXT];
      c_hist_q[mcc_pkg::H_NEXT]  <= cn_q;
      last_lw_q <= lw_cap_q;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q.pfilt_out   <= pq[15:0];
      out_q.pfilt_next  <= pn_q;
      out_q.pfilt_cur   <= p_hist_q[mcc_pkg::H_NEXT];
      out_q.pfilt_prev  <= p_hist_q[mcc_pkg::H_CUR];
      out_q.pfilt_prev2 <= p_hist_q[mcc_pkg::H_PREV];
      out_q.comb_out    <= (cq > 19'sd32767) ? 16'sh7FFF : cq[15:0];
      out_q.comb_next   <= cn_q;
      out_q.comb_cur    <= c_hist_q[mcc_pkg::H_NEXT];
      out_q.comb_prev   <= c_hist_q[mcc_pkg::H_CUR];
      out_q.comb_prev2  <= c_hist_q[mcc_pkg::H_PREV];
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== rtl/mcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// mcc_ctrl: controller of the misfire crank criteria unit
// Sequences the rescale, the two divisions and the commit, owns the handshake.
// ----------------------------------------------------------------------------
module mcc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  mcc_pkg::sts_t sts_i,
  output mcc_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_P1_GO   = 3'd1;
  localparam logic [2:0] S_P2_GO   = 3'd3;
  localparam logic [2:0] S_P2_WAIT = 3'd4;
  localparam logic [2:0] S_C_GO    = 3'd5;
  localparam logic [2:0] S_C_WAIT  = 3'd6;
  localparam logic [2:0] S_COMMIT  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  // next state and commands
  always_comb begin
    state_d           = state_q;
    cmd_o.load        = 1'b0;
    cmd_o.div_start   = 1'b0;
    cmd_o.div_sel     = mcc_pkg::DIV_PRESS_SCALE;
    cmd_o.div_capture = 1'b0;
    cmd_o.commit      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_P1_GO;
        end
      end
      S_P1_GO: begin
        cmd_o.div_capture = 1'b1;
        state_d           = S_P2_GO;
      end
      S_P2_GO: begin
        cmd_o.div_sel   = mcc_pkg::DIV_PRESS_NORM;
        cmd_o.div_start = 1'b1;
        state_d         = S_P2_WAIT;
      end
      S_P2_WAIT: begin
        cmd_o.div_sel = mcc_pkg::DIV_PRESS_NORM;
        if (sts_i.div_done) begin
          cmd_o.div_capture = 1'b1;
          state_d           = S_C_GO;
        end
      end
      S_C_GO: begin
        cmd_o.div_sel   = mcc_pkg::DIV_COMB;
        cmd_o.div_start = 1'b1;
        state_d         = S_C_WAIT;
      end
      S_C_WAIT: begin
        cmd_o.div_sel = mcc_pkg::DIV_COMB;
        if (sts_i.div_done) begin
          cmd_o.div_capture = 1'b1;
          state_d           = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit)      out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/misfire_crank_criteria_unit.sv =====
// ----------------------------------------------------------------------------
// misfire_crank_criteria_unit: pressure and combustion criteria per event
// Takes one set of crank window timings per combustion event and returns both
// four-deep criterion histories with their second differences.
// ----------------------------------------------------------------------------
// Usage
//   Input channel in_valid_i / in_stall_o / in_data_i carries one item per
//   combustion event. Output channel out_valid_o / out_stall_i / out_data_o
//   returns exactly one item for each accepted input item, in order.
//   An item is taken while in_stall_o is low, i.e. while the unit is idle.
//   The long-window rescale by 16384/15625 is a reciprocal multiplication.
//   The half-revolution normalisation and the combustion ratio run one
//   after another on one shared bit-serial divider, each as a start step,
//   32 quotient bits and a capture step. After acceptance the unit loads the
//   item, captures the rescale, runs both divisions and commits the result
//   once the output is free; it is idle again when out_valid_o rises, so
//   items are taken one at a time.
//   A finished item sits in the output register; the next item may be taken
//   and worked on meanwhile, but its result waits at the commit step while
//   out_stall_i holds the previous one, and histories shift only at commit.
//   Reset clears both histories, the stored long window, the controller state
//   and the output valid flag.
// ----------------------------------------------------------------------------
module misfire_crank_criteria_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mcc_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mcc_pkg::out_item_t out_data_o
);

  mcc_pkg::cmd_t cmd;
  mcc_pkg::sts_t sts;

  mcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mcc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

// ===== rtl/mcc_checker.sv =====
// ----------------------------------------------------------------------------
// mcc_checker: port-level checks of the misfire crank criteria unit
// Bound to the top level; watches both handshakes over time.
// ----------------------------------------------------------------------------
module mcc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input mcc_pkg::out_item_t out_data_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // a held result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  // one item at a time: busy right after an accepted item
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input taken again while busy");

  // a new result never appears right after an item is taken
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_o))
    else $error("result appeared without computation time");

  // a fresh result comes with the unit ready again
  a_ready_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result shown while still busy");

endmodule

bind misfire_crank_criteria_unit mcc_checker u_mcc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== bench/mcc_criteria_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcc_criteria_checker: scoreboard for the misfire crank criteria unit
// Watches both channels, keeps its own copy of the criterion histories and the
// stored long window, works out the result item for every accepted input item
// and compares each returned item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module mcc_criteria_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  mcc_pkg::in_item_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  mcc_pkg::out_item_t out_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int NUM_FIELDS = 10;
  localparam int FIELD_W    = 16;
  localparam int ITEM_W     = NUM_FIELDS * FIELD_W;

  // predictor state: criterion histories and the stored long window
  int          press_hist [4];
  int          comb_hist  [4];
  logic [17:0] held_lw;

  mcc_pkg::out_item_t crit_q [$];
  mcc_pkg::out_item_t want;
  int          fail_cnt = 0;
  int          result_idx;
  string       field_name [NUM_FIELDS];

  initial begin
    field_name = '{"pfilt_out", "pfilt_next", "pfilt_cur", "pfilt_prev", "pfilt_prev2",
                   "comb_out", "comb_next", "comb_cur", "comb_prev", "comb_prev2"};
  end

  assign fail_count_o = fail_cnt;

  // pressure criterion from the long window change and the half revolution sum
  function automatic int press_criterion(logic [31:0] lw, logic [15:0] hrs);
    logic              up;
    logic [31:0]       delta;
    longint unsigned   t;
    up    = lw > {14'd0, held_lw};
    delta = up ? lw - {14'd0, held_lw} : {14'd0, held_lw} - lw;
    if (delta > {14'd0, mcc_pkg::DELTA_CLAMP}) delta = {14'd0, mcc_pkg::DELTA_CLAMP};
    if (hrs == 16'd0) return up ? 32767 : -32768;
    t = 64'(delta);
    t = t * 64'd16384 / mcc_pkg::SCALE_DIVISOR;
    t = t * 64'd8192 / (64'd5 * hrs);
    if (up) return (t > 64'd32767) ? 32767 : int'(t);
    if (t > 64'd32768) t = 64'd32768;
    return -int'(t);
  endfunction

  // combustion criterion (2 * exp - tdc - bdc) * 32768 / exp, saturated
  function automatic int comb_criterion(logic [31:0] tdc, logic [31:0] ex, logic [31:0] bdc);
    logic [31:0]     dbl;
    logic [32:0]     wide_sum;
    logic [31:0]     sum;
    logic [31:0]     delta;
    logic            neg;
    longint unsigned q;
    if (ex == 32'd0) return 32767;
    dbl      = (ex >= mcc_pkg::DBL_LIMIT) ? 32'hFFFF_FFFF : {ex[30:0], 1'b0};
    wide_sum = {1'b0, tdc} + {1'b0, bdc};
    sum      = wide_sum[32] ? 32'hFFFF_FFFF : wide_sum[31:0];
    neg      = sum > dbl;
    delta    = neg ? sum - dbl : dbl - sum;
    // large differences are divided first, the product then saturates
    if (delta > mcc_pkg::BIG_DIFF) begin
      q = 64'(delta / ex);
      q = q << 15;
    end else begin
      q = 64'(delta);
      q = (q << 15) / ex;
    end
    if (neg) begin
      if (q > 64'd32768) q = 64'd32768;
      return -int'(q);
    end
    return (q > 64'd32767) ? 32767 : int'(q);
  endfunction

  // advance both histories by one event and build the expected result item
  function automatic mcc_pkg::out_item_t next_criteria(mcc_pkg::in_item_t it);
    mcc_pkg::out_item_t r;
    int        pn;
    int        cn;
    int        po;
    int        co;
    pn = press_criterion(it.long_win_delay, it.half_rev_sum);
    cn = comb_criterion(it.tdc_win_delay, it.exp_win_delay, it.bdc_win_delay);
    for (int k = 0; k < 3; k++) begin
      press_hist[k] = press_hist[k+1];
      comb_hist[k]  = comb_hist[k+1];
    end
    press_hist[mcc_pkg::H_NEXT] = pn;
    comb_hist[mcc_pkg::H_NEXT]  = cn;
    held_lw = (it.long_win_delay > mcc_pkg::LW_CAP) ? mcc_pkg::LW_CAP[17:0]
                                                    : it.long_win_delay[17:0];

    po = (2 * press_hist[mcc_pkg::H_CUR]
          - (press_hist[mcc_pkg::H_NEXT] + press_hist[mcc_pkg::H_PREV])) / 4;
    co = (2 * comb_hist[mcc_pkg::H_CUR]
          - (comb_hist[mcc_pkg::H_NEXT] + comb_hist[mcc_pkg::H_PREV]) + 2) / 4;
    if (co > 32767) co = 32767;
    if (co < -32768) co = -32768;

    r.pfilt_out   = po[15:0];
    r.pfilt_next  = press_hist[mcc_pkg::H_NEXT][15:0];
    r.pfilt_cur   = press_hist[mcc_pkg::H_CUR][15:0];
    r.pfilt_prev  = press_hist[mcc_pkg::H_PREV][15:0];
    r.pfilt_prev2 = press_hist[mcc_pkg::H_PREV2][15:0];
    r.comb_out    = co[15:0];
    r.comb_next   = comb_hist[mcc_pkg::H_NEXT][15:0];
    r.comb_cur    = comb_hist[mcc_pkg::H_CUR][15:0];
    r.comb_prev   = comb_hist[mcc_pkg::H_PREV][15:0];
    r.comb_prev2  = comb_hist[mcc_pkg::H_PREV2][15:0];
    return r;
  endfunction

  // channel monitor: check returned items first, then queue new predictions
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 4; k++) begin
        press_hist[k] = 0;
        comb_hist[k]  = 0;
      end
      held_lw    = '0;
      result_idx = 0;
      crit_q.delete();
      pending_o  = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (crit_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("result %0d arrived with nothing expected: %h", result_idx, out_data_i);
        end else begin
          want = crit_q.pop_front();
          for (int f = 0; f < NUM_FIELDS; f++) begin
            if (out_data_i[ITEM_W-1-FIELD_W*f -: FIELD_W] !==
                want[ITEM_W-1-FIELD_W*f -: FIELD_W]) begin
              fail_cnt++;
              if (fail_cnt <= 10)
                $display("result %0d %s: expected %0d, got %0d", result_idx, field_name[f],
                         $signed(want[ITEM_W-1-FIELD_W*f -: FIELD_W]),
                         $signed(out_data_i[ITEM_W-1-FIELD_W*f -: FIELD_W]));
            end
          end
        end
        result_idx++;
      end
      if (in_valid_i && !in_stall_i) crit_q.push_back(next_criteria(in_data_i));
      pending_o = crit_q.size();
    end
  end

endmodule

// ===== bench/misfire_crank_criteria_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// misfire_crank_criteria_unit_tb: stimulus and verdict for the criteria unit
// Sends a directed set of crank timing items covering clamps, zero divisors
// and saturations, then randomised events with random gaps and output stalls,
// one long output hold-off and a full drain mid-run and at the end. The checker does the scoring.
// ----------------------------------------------------------------------------
module misfire_crank_criteria_unit_tb;

  localparam int NUM_RANDOM  = 735;
  localparam int PAUSE_AT    = 450;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 800;
  localparam int DRAIN       = 150;
  localparam int CYCLE_LIMIT = 600000;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  mcc_pkg::in_item_t  in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  mcc_pkg::out_item_t out_data_o;
  int                 fail_count;
  int                 pending;
  int                 cycle_cnt = 0;

  misfire_crank_criteria_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  mcc_criteria_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 12 ns clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic mcc_pkg::in_item_t crank_event(logic [31:0] lw, logic [15:0] hrs,
                                                    logic [31:0] tdc, logic [31:0] ex,
                                                    logic [31:0] bdc);
    mcc_pkg::in_item_t it;
    it.long_win_delay = lw;
    it.half_rev_sum   = hrs;
    it.tdc_win_delay  = tdc;
    it.exp_win_delay  = ex;
    it.bdc_win_delay  = bdc;
    return it;
  endfunction

  // random event: mostly plausible timings near the last one, some wide noise
  function automatic mcc_pkg::in_item_t rand_event(logic [31:0] lw_prev);
    mcc_pkg::in_item_t it;
    case ($urandom_range(0, 5))
      0:       it.long_win_delay = $urandom;
      1:       it.long_win_delay = $urandom_range(0, 262143);
      2, 3:    it.long_win_delay = lw_prev + $urandom_range(0, 2000) - 1000;
      4: begin
        case ($urandom_range(0, 3))
          0:       it.long_win_delay = 32'd0;
          1:       it.long_win_delay = 32'd199999;
          2:       it.long_win_delay = 32'd200000;
          default: it.long_win_delay = 32'hFFFF_FFFF;
        endcase
      end
      default: it.long_win_delay = $urandom_range(100000, 199999);
    endcase
    case ($urandom_range(0, 7))
      0:       it.half_rev_sum = 16'd0;
      1, 2:    it.half_rev_sum = 16'($urandom_range(0, 65535));
      3, 4:    it.half_rev_sum = 16'($urandom_range(1, 64));
      default: it.half_rev_sum = 16'($urandom_range(200, 4000));
    endcase
    case ($urandom_range(0, 7))
      0:       it.exp_win_delay = 32'd0;
      1:       it.exp_win_delay = $urandom;
      2:       it.exp_win_delay = 32'h7FFF_FFFF + $urandom_range(0, 2) - 1;
      default: it.exp_win_delay = $urandom_range(1, 200000);
    endcase
    if ($urandom_range(0, 3) == 0) begin
      it.tdc_win_delay = $urandom;
      it.bdc_win_delay = $urandom;
    end else begin
      it.tdc_win_delay = it.exp_win_delay + $urandom_range(0, 4000) - 2000;
      it.bdc_win_delay = it.exp_win_delay + $urandom_range(0, 4000) - 2000;
    end
    return it;
  endfunction

  // offer one item after a random gap and hold it until taken
  task automatic send_event(input mcc_pkg::in_item_t it, input int idx);
    int   gap;
    logic taken;
    gap = (((idx / 60) % 4) == 1) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // wait until every expected result item has come back
  task automatic wait_drained();
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  // result side: random stalls, stall-free stretches and one long hold-off
  initial begin : result_sink
    int   hold;
    int   rx_cnt;
    logic taken;
    rx_cnt = 0;
    out_stall_i <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (rx_cnt == HOLD_AT) hold = HOLD_CYCLES;
      else if (((rx_cnt / 50) % 4) == 2) hold = 0;
      else hold = $urandom_range(0, 16);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do begin
        @(negedge clk_i);
        taken = out_valid_o;
        @(posedge clk_i);
      end while (!taken);
      rx_cnt++;
    end
  end

  // stimulus and verdict
  initial begin : event_source
    mcc_pkg::in_item_t directed_q [$];
    mcc_pkg::in_item_t it;
    logic [31:0]       lw_prev;
    int                idx;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all zero: equal windows with zero sum, zero expansion time
    directed_q.push_back(crank_event(32'd0, 16'd0, 32'd0, 32'd0, 32'd0));
    // rising window with zero sum, balanced combustion
    directed_q.push_back(crank_event(32'd1, 16'd0, 32'd10, 32'd5, 32'd0));
    // time change clamp, saturated sum and saturated doubled expansion
    directed_q.push_back(crank_event(32'hFFFF_FFFF, 16'd1, 32'hFFFF_FFFF,
                                     32'h7FFF_FFFF, 32'hFFFF_FFFF));
    // falling from the capped stored window, largest sum, positive large diff
    directed_q.push_back(crank_event(32'd0, 16'hFFFF, 32'd0, 32'hFFFF_FFFF, 32'd0));
    // equal windows with nonzero sum
    directed_q.push_back(crank_event(32'd0, 16'd100, 32'd1000, 32'd1000, 32'd1000));
    // rising saturation, positive large difference with saturating product
    directed_q.push_back(crank_event(32'd300000, 16'd1, 32'd0, 32'h4000_0000, 32'd0));
    // falling saturation, negative saturation
    directed_q.push_back(crank_event(32'd0, 16'd1, 32'h8000_0000, 32'd3, 32'h8000_0000));
    // stored window cap, then an equal window at the cap
    directed_q.push_back(crank_event(32'd250000, 16'd1, 32'd100, 32'd101, 32'd100));
    directed_q.push_back(crank_event(32'd199999, 16'd1, 32'hFFFF_FFFF, 32'd12345, 32'd1));
    // alternating full-scale pressure criterion: drives its second difference to its limits
    directed_q.push_back(crank_event(32'd0, 16'd1, 32'd0, 32'hFFFF_FFFF, 32'd0));
    directed_q.push_back(crank_event(32'd300000, 16'd1, 32'd0, 32'd0, 32'd0));
    directed_q.push_back(crank_event(32'd0, 16'd1, 32'd0, 32'hFFFF_FFFF, 32'd0));
    directed_q.push_back(crank_event(32'd300000, 16'd1, 32'd0, 32'd0, 32'd0));
    // mid-range values on both criteria, then both criteria saturating negative
    directed_q.push_back(crank_event(32'd200100, 16'd500, 32'd3000, 32'd2000, 32'd1500));
    directed_q.push_back(crank_event(32'd150000, 16'd2500, 32'd262143, 32'd65536, 32'd0));
    // difference just over the large-difference threshold, then a small one
    directed_q.push_back(crank_event(32'd150001, 16'd2500, 32'd131073, 32'd1, 32'd1));
    directed_q.push_back(crank_event(32'd149000, 16'd3000, 32'd131073, 32'd65536, 32'd0));

    idx     = 0;
    lw_prev = '0;
    foreach (directed_q[k]) begin
      send_event(directed_q[k], idx);
      idx++;
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == PAUSE_AT) begin
        in_valid_i <= 1'b0;
        wait_drained();
      end
      it      = rand_event(lw_prev);
      lw_prev = it.long_win_delay;
      send_event(it, idx);
      idx++;
    end
    in_valid_i <= 1'b0;

    wait_drained();
    repeat (DRAIN) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/mcc_pkg.sv
rtl/mcc_div.sv
rtl/mcc_dp.sv
rtl/mcc_ctrl.sv
rtl/misfire_crank_criteria_unit.sv
rtl/mcc_checker.sv
bench/mcc_criteria_checker.sv
bench/misfire_crank_criteria_unit_tb.sv
